[sv/cal_adv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_adv_pkg
// Types, constants and per-stage step functions of the calendar advance block.
// ----------------------------------------------------------------------------
package cal_adv_pkg;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } cal_op_e;

  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned HOUR_PER_DAY = 24;
  localparam int unsigned DAY_PER_WEEK = 7;
  localparam int unsigned MONTH_MAX    = 12;
  localparam int unsigned YEAR_MAX     = 99;

  // Reset base: midnight, Saturday 1 January 2000, tick zero.
  localparam logic [5:0]  RST_SECOND  = 6'd0;
  localparam logic [5:0]  RST_MINUTE  = 6'd0;
  localparam logic [4:0]  RST_HOUR    = 5'd0;
  localparam logic [2:0]  RST_WEEKDAY = 3'd6;
  localparam logic [4:0]  RST_DAY     = 5'd1;
  localparam logic [3:0]  RST_MONTH   = 4'd1;
  localparam logic [6:0]  RST_YEAR    = 7'd0;
  localparam logic [31:0] RST_TICK    = 32'd0;

  // Reciprocal multipliers: exact floor division over the value range in use.
  localparam logic [28:0] DIV1000_MUL  = 29'h10624DD3;  // 32-bit tick / 1000
  localparam int unsigned DIV1000_SHR  = 38;
  localparam logic [23:0] DIV60S_MUL   = 24'd8947849;   // 23-bit / 60
  localparam int unsigned DIV60S_SHR   = 29;
  localparam logic [17:0] DIV60M_MUL   = 18'd139811;    // 17-bit / 60
  localparam int unsigned DIV60M_SHR   = 23;
  localparam logic [10:0] DIV24_MUL    = 11'd1366;      // 11-bit / 24
  localparam int unsigned DIV24_SHR    = 15;
  localparam logic [5:0]  DIV7_MUL     = 6'd37;         // 6-bit (< 57) / 7
  localparam int unsigned DIV7_SHR     = 8;

  localparam int unsigned MONTH_STEPS  = 4;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic [5:0]  set_second;
    logic [5:0]  set_minute;
    logic [4:0]  set_hour;
    logic [2:0]  set_weekday;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [6:0]  set_year;
  } cal_in_t;

  // Item travelling down the pipeline. Accepted sets carry final fields; queries carry
  // the base fields plus a running value and quotient that each step refines.
  typedef struct packed {
    logic        query;
    logic        acc;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [6:0]  year;
    logic [31:0] work;
    logic [22:0] quo;
  } cal_pipe_t;

  function automatic logic [4:0] month_len(logic [3:0] mon, logic [6:0] year);
    logic [4:0] len;
    case (mon)
      4'd2:                      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Elapsed whole seconds from the tick difference.
  function automatic cal_pipe_t step_elapsed(cal_pipe_t p);
    cal_pipe_t   r;
    logic [60:0] prod;
    r    = p;
    prod = 61'(p.work) * 61'(DIV1000_MUL);
    if (p.query) begin
      r.work = 32'(prod >> DIV1000_SHR);
    end
    return r;
  endfunction

  // Total seconds and carry into minutes.
  function automatic cal_pipe_t step_second(cal_pipe_t p);
    cal_pipe_t   r;
    logic [22:0] total;
    logic [46:0] prod;
    r     = p;
    total = 23'(p.sec) + p.work[22:0];
    prod  = 47'(total) * 47'(DIV60S_MUL);
    if (p.query) begin
      r.work = 32'(total);
      r.quo  = 23'(prod >> DIV60S_SHR);
    end
    return r;
  endfunction

  // Second remainder, total minutes and carry into hours.
  function automatic cal_pipe_t step_minute(cal_pipe_t p);
    cal_pipe_t   r;
    logic [16:0] mins;
    logic [34:0] prod;
    r    = p;
    mins = 17'(p.min) + p.quo[16:0];
    prod = 35'(mins) * 35'(DIV60M_MUL);
    if (p.query) begin
      r.sec  = p.work[5:0] - 6'(p.quo[5:0] * 6'(SEC_PER_MIN));
      r.work = 32'(mins);
      r.quo  = 23'(prod >> DIV60M_SHR);
    end
    return r;
  endfunction

  // Minute remainder, total hours and carry into days.
  function automatic cal_pipe_t step_hour(cal_pipe_t p);
    cal_pipe_t   r;
    logic [10:0] hours;
    logic [21:0] prod;
    r     = p;
    hours = 11'(p.hour) + p.quo[10:0];
    prod  = 22'(hours) * 22'(DIV24_MUL);
    if (p.query) begin
      r.min  = p.work[5:0] - 6'(p.quo[5:0] * 6'(MIN_PER_HOUR));
      r.work = 32'(hours);
      r.quo  = 23'(prod >> DIV24_SHR);
    end
    return r;
  endfunction

  // Hour remainder, weekday and raw day of month.
  function automatic cal_pipe_t step_weekday(cal_pipe_t p);
    cal_pipe_t   r;
    logic [5:0]  days;
    logic [5:0]  wsum;
    logic [11:0] prod;
    logic [3:0]  wq;
    r    = p;
    days = p.quo[5:0];
    wsum = 6'(p.wday) + days;
    prod = 12'(wsum) * 12'(DIV7_MUL);
    wq   = 4'(prod >> DIV7_SHR);
    if (p.query) begin
      r.hour = p.work[4:0] - 5'(p.quo[4:0] * 5'(HOUR_PER_DAY));
      r.wday = wsum[2:0] - 3'(wq[2:0] * 3'(DAY_PER_WEEK));
      r.work = 32'(7'(p.day) + 7'(days));
    end
    return r;
  endfunction

  // Roll the day through month ends, wrapping the year past 2099.
  function automatic cal_pipe_t step_month(cal_pipe_t p);
    cal_pipe_t  r;
    logic [6:0] d;
    logic [3:0] mon;
    logic [6:0] yr;
    logic [4:0] len;
    logic       done;
    r    = p;
    d    = p.work[6:0];
    mon  = p.mon;
    yr   = p.year;
    done = 1'b0;
    for (int k = 0; k < MONTH_STEPS; k++) begin
      len = month_len(mon, yr);
      if (!done && d > 7'(len)) begin
        d   = d - 7'(len);
        mon = mon + 4'd1;
        if (mon > 4'(MONTH_MAX)) begin
          mon = 4'd1;
          yr  = (yr >= 7'(YEAR_MAX)) ? 7'd0 : yr + 7'd1;
        end
      end else begin
        done = 1'b1;
      end
    end
    if (p.query) begin
      r.day  = d[4:0];
      r.mon  = mon;
      r.year = yr;
    end
    return r;
  endfunction

endpackage

[sv/cal_adv_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_adv_req_if
// Request channel: set or query item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cal_adv_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_ms;
  logic [5:0]  set_second;
  logic [5:0]  set_minute;
  logic [4:0]  set_hour;
  logic [2:0]  set_weekday;
  logic [4:0]  set_day;
  logic [3:0]  set_month;
  logic [6:0]  set_year;

  modport source (
    output valid, op, now_ms, set_second, set_minute, set_hour, set_weekday,
           set_day, set_month, set_year,
    input  ready
  );

  modport sink (
    input  valid, op, now_ms, set_second, set_minute, set_hour, set_weekday,
           set_day, set_month, set_year,
    output ready
  );
endinterface

[sv/cal_adv_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_adv_rsp_if
// Result channel: calendar time and accept flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cal_adv_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [4:0] day;
  logic [3:0] month;
  logic [6:0] year;
  logic       accepted;

  modport source (
    output valid, second, minute, hour, weekday, day, month, year, accepted,
    input  ready
  );

  modport sink (
    input  valid, second, minute, hour, weekday, day, month, year, accepted,
    output ready
  );
endinterface

[sv/calendar_advance_by_elapsed_ms.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_advance_by_elapsed_ms
// Calendar clock: stores a base time with its ms tick, reports the time
// advanced by whole elapsed seconds on each query.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the result channel back-pressures;
//   each step is one reciprocal multiply or a short compare/subtract chain,
//   so the eight-register pipeline streams.
// Reset: base time is 00:00:00 Saturday 1 January 2000 at tick 0; all
//   pipeline stages are emptied.
// ----------------------------------------------------------------------------
module calendar_advance_by_elapsed_ms
  import cal_adv_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  cal_adv_req_if.sink   req_i,
  cal_adv_rsp_if.source rsp_o
);

  // Stage handshakes between the three pipeline sections.
  cal_in_t   in_data;
  logic      base_valid;
  logic      base_ready;
  cal_pipe_t base_data;
  logic      carry_valid;
  logic      carry_ready;
  cal_pipe_t carry_data;
  logic      res_valid;
  cal_pipe_t res_data;

  // Gather the request payload into one struct.
  always_comb begin
    in_data.op          = req_i.op;
    in_data.now_ms      = req_i.now_ms;
    in_data.set_second  = req_i.set_second;
    in_data.set_minute  = req_i.set_minute;
    in_data.set_hour    = req_i.set_hour;
    in_data.set_weekday = req_i.set_weekday;
    in_data.set_day     = req_i.set_day;
    in_data.set_month   = req_i.set_month;
    in_data.set_year    = req_i.set_year;
  end

  // Input register plus base store. A legal set commits the base as it leaves
  // the input register, so every later query in the pipe already sees it.
  cal_adv_base u_base (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (in_data),
    .out_valid_o (base_valid),
    .out_ready_i (base_ready),
    .out_data_o  (base_data)
  );

  // Divide the tick difference by 1000, then carry seconds up to days.
  cal_adv_carry u_carry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (base_valid),
    .in_ready_o  (base_ready),
    .in_data_i   (base_data),
    .out_valid_o (carry_valid),
    .out_ready_i (carry_ready),
    .out_data_o  (carry_data)
  );

  // Weekday, then month and year roll-over; last stage is the result register.
  cal_adv_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (carry_valid),
    .in_ready_o  (carry_ready),
    .in_data_i   (carry_data),
    .out_valid_o (res_valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (res_data)
  );

  // Drive the result channel straight from the result register.
  assign rsp_o.valid    = res_valid;
  assign rsp_o.second   = res_data.sec;
  assign rsp_o.minute   = res_data.min;
  assign rsp_o.hour     = res_data.hour;
  assign rsp_o.weekday  = res_data.wday;
  assign rsp_o.day      = res_data.day;
  assign rsp_o.month    = res_data.mon;
  assign rsp_o.year     = res_data.year;
  assign rsp_o.accepted = res_data.acc;

`ifndef ASSERT_OFF
  // Every result field lies in its legal calendar range.
  a_result_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.second < 6'(SEC_PER_MIN)) && (rsp_o.minute < 6'(MIN_PER_HOUR))
      && (rsp_o.hour < 5'(HOUR_PER_DAY)) && (rsp_o.weekday < 3'(DAY_PER_WEEK))
      && (rsp_o.day != 5'd0) && (rsp_o.month != 4'd0) && (rsp_o.month <= 4'(MONTH_MAX))
      && (rsp_o.year <= 7'(YEAR_MAX)))
    else $error("result time out of range");

  // Only a rejected set may clear the accepted flag.
  a_query_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_data.acc |-> !res_data.query)
    else $error("query result without accepted flag");

  // The request side stalls only when the whole pipe is backed up.
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("request stalled without output back-pressure");
`endif

endmodule

[sv/cal_adv_base.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_adv_base
// Input register, range check and base time store; starts each query.
// ----------------------------------------------------------------------------
module cal_adv_base
  import cal_adv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cal_in_t   in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cal_pipe_t out_data_o
);

  logic        in_valid_q;
  cal_in_t     in_data_q;
  logic        pipe_valid_q;
  cal_pipe_t   pipe_data_q;
  cal_pipe_t   pipe_data_d;
  logic        pipe_ready;
  logic        set_ok;
  logic        is_query;
  logic        base_we;

  logic [5:0]  base_second_q;
  logic [5:0]  base_minute_q;
  logic [4:0]  base_hour_q;
  logic [2:0]  base_weekday_q;
  logic [4:0]  base_day_q;
  logic [3:0]  base_month_q;
  logic [6:0]  base_year_q;
  logic [31:0] base_tick_q;

  assign pipe_ready = !pipe_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || pipe_ready;

  assign is_query = (in_data_q.op == OP_QUERY);
  assign set_ok   = (in_data_q.set_second < 6'(SEC_PER_MIN))
                 && (in_data_q.set_minute < 6'(MIN_PER_HOUR))
                 && (in_data_q.set_hour < 5'(HOUR_PER_DAY))
                 && (in_data_q.set_weekday < 3'(DAY_PER_WEEK))
                 && (in_data_q.set_day != 5'd0)
                 && (in_data_q.set_month != 4'd0)
                 && (in_data_q.set_month <= 4'(MONTH_MAX))
                 && (in_data_q.set_year <= 7'(YEAR_MAX));
  assign base_we  = in_valid_q && pipe_ready && !is_query && set_ok;

  always_comb begin
    pipe_data_d       = '0;
    pipe_data_d.query = is_query;
    pipe_data_d.acc   = is_query || set_ok;
    if (!is_query && set_ok) begin
      pipe_data_d.sec  = in_data_q.set_second;
      pipe_data_d.min  = in_data_q.set_minute;
      pipe_data_d.hour = in_data_q.set_hour;
      pipe_data_d.wday = in_data_q.set_weekday;
      pipe_data_d.day  = in_data_q.set_day;
      pipe_data_d.mon  = in_data_q.set_month;
      pipe_data_d.year = in_data_q.set_year;
    end else begin
      pipe_data_d.sec  = base_second_q;
      pipe_data_d.min  = base_minute_q;
      pipe_data_d.hour = base_hour_q;
      pipe_data_d.wday = base_weekday_q;
      pipe_data_d.day  = base_day_q;
      pipe_data_d.mon  = base_month_q;
      pipe_data_d.year = base_year_q;
    end
    if (is_query) begin
      pipe_data_d.work = in_data_q.now_ms - base_tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      pipe_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (pipe_ready) begin
        pipe_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (pipe_ready && in_valid_q) begin
      pipe_data_q <= pipe_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_second_q  <= RST_SECOND;
      base_minute_q  <= RST_MINUTE;
      base_hour_q    <= RST_HOUR;
      base_weekday_q <= RST_WEEKDAY;
      base_day_q     <= RST_DAY;
      base_month_q   <= RST_MONTH;
      base_year_q    <= RST_YEAR;
      base_tick_q    <= RST_TICK;
    end else if (base_we) begin
      base_second_q  <= in_data_q.set_second;
      base_minute_q  <= in_data_q.set_minute;
      base_hour_q    <= in_data_q.set_hour;
      base_weekday_q <= in_data_q.set_weekday;
      base_day_q     <= in_data_q.set_day;
      base_month_q   <= in_data_q.set_month;
      base_year_q    <= in_data_q.set_year;
      base_tick_q    <= in_data_q.now_ms;
    end
  end

  assign out_valid_o = pipe_valid_q;
  assign out_data_o  = pipe_data_q;

endmodule

[sv/cal_adv_carry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_adv_carry
// Four stages: ms to seconds, then carries through seconds, minutes, hours.
// ----------------------------------------------------------------------------
module cal_adv_carry
  import cal_adv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cal_pipe_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cal_pipe_t out_data_o
);

  localparam int unsigned NSTAGE = 4;

  logic      valid_q [NSTAGE];
  cal_pipe_t data_q  [NSTAGE];
  cal_pipe_t data_d  [NSTAGE];
  logic      up_valid[NSTAGE];
  logic      ready   [NSTAGE+1];

  always_comb begin
    data_d[0] = step_elapsed(in_data_i);
    data_d[1] = step_second(data_q[0]);
    data_d[2] = step_minute(data_q[1]);
    data_d[3] = step_hour(data_q[2]);
  end

  assign ready[NSTAGE] = out_ready_i;

  for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign up_valid[i] = in_valid_i;
    end else begin : g_next
      assign up_valid[i] = valid_q[i-1];
    end

    assign ready[i] = !valid_q[i] || ready[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (ready[i]) begin
        valid_q[i] <= up_valid[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[i] && up_valid[i]) begin
        data_q[i] <= data_d[i];
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NSTAGE-1];
  assign out_data_o  = data_q[NSTAGE-1];

endmodule

[sv/cal_adv_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_adv_norm
// Weekday and day sum, then month roll-over into the result register.
// ----------------------------------------------------------------------------
module cal_adv_norm
  import cal_adv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cal_pipe_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cal_pipe_t out_data_o
);

  logic      day_valid_q;
  cal_pipe_t day_data_q;
  logic      res_valid_q;
  cal_pipe_t res_data_q;
  logic      day_ready;
  logic      res_ready;

  assign res_ready  = !res_valid_q || out_ready_i;
  assign day_ready  = !day_valid_q || res_ready;
  assign in_ready_o = day_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (day_ready) begin
        day_valid_q <= in_valid_i;
      end
      if (res_ready) begin
        res_valid_q <= day_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (day_ready && in_valid_i) begin
      day_data_q <= step_weekday(in_data_i);
    end
    if (res_ready && day_valid_q) begin
      res_data_q <= step_month(day_data_q);
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_data_q;

endmodule
